FILE: rtl/jpeg_scan_start_finder_macros.svh
// ----------------------------------------------------------------------------
// JPEG scan start finder: assertion macros
// Concurrent assertion shorthands. Each one samples on clk and is disabled
// while rst_n is low, so the using module must have both names in scope.
// ----------------------------------------------------------------------------
`ifndef JPEG_SCAN_START_FINDER_MACROS_SVH
`define JPEG_SCAN_START_FINDER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define JSSF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define JSSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/jssf_pkg.sv
// ----------------------------------------------------------------------------
// jssf_pkg
// Types, marker codes and decode helpers for the JPEG scan start finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jssf_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int SCAN_OFFSET_W   = 24;
    localparam int STATUS_W        = 3;

    localparam logic [7:0]  MARKER_PREFIX = 8'hFF;
    localparam logic [7:0]  CODE_RST0     = 8'hD0;  // standalone range start
    localparam logic [7:0]  CODE_EOI      = 8'hD9;  // standalone range end
    localparam logic [7:0]  CODE_SOS      = 8'hDA;
    localparam logic [7:0]  CODE_SOF0     = 8'hC0;
    localparam logic [7:0]  CODE_SOF15    = 8'hCF;
    localparam logic [7:0]  CODE_DQT      = 8'hDB;
    localparam logic [7:0]  CODE_DFF      = 8'hDF;
    localparam logic [7:0]  CODE_APP0     = 8'hE0;
    localparam logic [7:0]  CODE_JPG0     = 8'hF0;
    localparam logic [7:0]  CODE_COM      = 8'hFE;
    localparam logic [15:0] SEG_LEN_MIN   = 16'd2;

    typedef enum logic [2:0] {
        PH_MHIGH = 3'd0,
        PH_MLOW  = 3'd1,
        PH_LHIGH = 3'd2,
        PH_LLOW  = 3'd3,
        PH_SKIP  = 3'd4,
        PH_WAIT  = 3'd5
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND    = 3'd0,
        ST_NONBASE  = 3'd1,
        ST_INVALID  = 3'd2,
        ST_NOSCAN   = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    // FFD0..FFD9: no length, passed over
    function automatic logic is_standalone(input logic [7:0] code);
        is_standalone = (code >= CODE_RST0) && (code <= CODE_EOI);
    endfunction

    function automatic logic has_length(input logic [7:0] code);
        has_length = ((code >= CODE_SOF0) && (code <= CODE_SOF15))
                  || ((code >= CODE_DQT)  && (code <= CODE_DFF))
                  || ((code >= CODE_APP0) && (code <  CODE_JPG0))
                  || ((code >= CODE_JPG0) && (code <= CODE_COM));
    endfunction

    // SOF1..3, 5..7, 9..11, 13..15: low two bits nonzero in the Cx row
    function automatic logic is_nonbaseline(input logic [7:0] code);
        is_nonbaseline = (code[7:4] == CODE_SOF0[7:4]) && (code[1:0] != 2'b00);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/jpeg_scan_start_finder.sv
// ----------------------------------------------------------------------------
// jpeg_scan_start_finder
// Walks the marker chain of a JPEG byte stream and reports one verdict per
// image: the offset just past the start-of-scan marker, or an error status.
// ----------------------------------------------------------------------------
// The block takes one byte per request and sustains one byte per clock
// cycle while out_stall does not hold the result register: each byte
// costs one 8-bit decode, one 16-bit length subtract or skip decrement
// and one offset-counter increment, all in a single stage between the
// input register and the result register. A byte is held in the input
// register and its verdict in the result register, which drives the
// outputs. Only a byte that completes a verdict (found, non-baseline
// SOF, invalid marker or length, end without scan, offset overflow)
// makes an output request; after the verdict, bytes are dropped until
// the byte flagged last_byte, which re-arms the parser for the next
// image. While the result register is held by out_stall, in_stall rises
// once the input register is also full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jpeg_scan_start_finder #(
    parameter int OFFSET_BITS = jssf_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // byte requests
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [7:0]                         data_byte,
    input  wire logic                               last_byte,
    // verdict requests
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [jssf_pkg::SCAN_OFFSET_W-1:0]      scan_offset,
    output logic [jssf_pkg::STATUS_W-1:0]           status
);

`include "jpeg_scan_start_finder_macros.svh"

    localparam int SCAN_W = jssf_pkg::SCAN_OFFSET_W;

    // input register
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    // parser state
    jssf_pkg::phase_t         phase_reg, phase_next;
    logic [7:0]               marker_high_reg, marker_high_next;
    logic [7:0]               length_high_reg, length_high_next;
    logic [15:0]              skip_left_reg, skip_left_next;
    logic [OFFSET_BITS-1:0]   byte_count_reg, byte_count_next;

    // result register
    logic                     out_valid_reg;
    logic [SCAN_W-1:0]        scan_offset_reg;
    jssf_pkg::status_t        status_reg;

    // per-byte outcome
    logic                     hit;
    jssf_pkg::status_t        hit_status;
    logic [OFFSET_BITS-1:0]   count_inc;
    logic [15:0]              seg_len;
    logic [15:0]              skip_dec;

    logic advance;
    logic consume;

    // the stage moves whenever the result slot is free or being drained
    assign advance  = !out_valid_reg || !out_stall;
    assign consume  = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    assign count_inc = byte_count_reg + OFFSET_BITS'(1);
    assign seg_len   = {length_high_reg, byte_reg};
    assign skip_dec  = skip_left_reg - 16'd1;

    // ---------------- input register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    // ---------------- verdict decode ----------------
    always_comb
    begin
        hit        = 1'b0;
        hit_status = jssf_pkg::ST_FOUND;
        if (phase_reg != jssf_pkg::PH_WAIT)
        begin
            if (&byte_count_reg)
            begin
                hit        = 1'b1;
                hit_status = jssf_pkg::ST_OVERFLOW;
            end
            else
            begin
                unique case (phase_reg)
                    jssf_pkg::PH_MLOW:
                    begin
                        if (marker_high_reg != jssf_pkg::MARKER_PREFIX)
                        begin
                            hit        = 1'b1;
                            hit_status = jssf_pkg::ST_INVALID;
                        end
                        else if (jssf_pkg::is_standalone(byte_reg))
                        begin
                            hit = 1'b0;
                        end
                        else if (byte_reg == jssf_pkg::CODE_SOS)
                        begin
                            hit        = 1'b1;
                            hit_status = jssf_pkg::ST_FOUND;
                        end
                        else if (jssf_pkg::has_length(byte_reg))
                        begin
                            if (jssf_pkg::is_nonbaseline(byte_reg))
                            begin
                                hit        = 1'b1;
                                hit_status = jssf_pkg::ST_NONBASE;
                            end
                        end
                        else
                        begin
                            hit        = 1'b1;
                            hit_status = jssf_pkg::ST_INVALID;
                        end
                    end
                    jssf_pkg::PH_LLOW:
                    begin
                        if (seg_len < jssf_pkg::SEG_LEN_MIN)
                        begin
                            hit        = 1'b1;
                            hit_status = jssf_pkg::ST_INVALID;
                        end
                    end
                    default:
                    begin
                        hit = 1'b0;
                    end
                endcase
            end
            // end of image with no verdict yet
            if (!hit && last_reg)
            begin
                hit        = 1'b1;
                hit_status = jssf_pkg::ST_NOSCAN;
            end
        end
    end

    // ---------------- next state ----------------
    always_comb
    begin
        phase_next       = phase_reg;
        marker_high_next = marker_high_reg;
        length_high_next = length_high_reg;
        skip_left_next   = skip_left_reg;
        byte_count_next  = byte_count_reg;

        if (phase_reg != jssf_pkg::PH_WAIT && !(&byte_count_reg))
        begin
            byte_count_next = count_inc;
            unique case (phase_reg)
                jssf_pkg::PH_MHIGH:
                begin
                    marker_high_next = byte_reg;
                    phase_next       = jssf_pkg::PH_MLOW;
                end
                jssf_pkg::PH_MLOW:
                begin
                    if (jssf_pkg::is_standalone(byte_reg))
                    begin
                        phase_next = jssf_pkg::PH_MHIGH;
                    end
                    else
                    begin
                        phase_next = jssf_pkg::PH_LHIGH;
                    end
                end
                jssf_pkg::PH_LHIGH:
                begin
                    length_high_next = byte_reg;
                    phase_next       = jssf_pkg::PH_LLOW;
                end
                jssf_pkg::PH_LLOW:
                begin
                    skip_left_next = seg_len - jssf_pkg::SEG_LEN_MIN;
                    if (seg_len == jssf_pkg::SEG_LEN_MIN)
                    begin
                        phase_next = jssf_pkg::PH_MHIGH;
                    end
                    else
                    begin
                        phase_next = jssf_pkg::PH_SKIP;
                    end
                end
                jssf_pkg::PH_SKIP:
                begin
                    skip_left_next = skip_dec;
                    if (skip_dec == 16'd0)
                    begin
                        phase_next = jssf_pkg::PH_MHIGH;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        // a verdict parks the parser; the last byte re-arms it
        if (hit)
        begin
            phase_next = jssf_pkg::PH_WAIT;
        end
        if (last_reg)
        begin
            phase_next       = jssf_pkg::PH_MHIGH;
            marker_high_next = 8'h00;
            length_high_next = 8'h00;
            skip_left_next   = 16'd0;
            byte_count_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= jssf_pkg::PH_MHIGH;
            marker_high_reg <= 8'h00;
            length_high_reg <= 8'h00;
            skip_left_reg   <= 16'd0;
            byte_count_reg  <= '0;
        end
        else if (consume)
        begin
            phase_reg       <= phase_next;
            marker_high_reg <= marker_high_next;
            length_high_reg <= length_high_next;
            skip_left_reg   <= skip_left_next;
            byte_count_reg  <= byte_count_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg && hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && hit)
        begin
            status_reg <= hit_status;
            // offset counts the bytes up to and including the SOS marker
            if (hit_status == jssf_pkg::ST_FOUND)
            begin
                scan_offset_reg <= SCAN_W'(count_inc);
            end
            else
            begin
                scan_offset_reg <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign scan_offset = scan_offset_reg;
    assign status      = status_reg;

    // ---------------- assertions ----------------
    `JSSF_ASSERT_NOW(a_offset_zero_unless_found,
        out_valid_reg && (status_reg != jssf_pkg::ST_FOUND), scan_offset_reg == '0,
        "nonzero offset on a non-found verdict")

    `JSSF_ASSERT_NOW(a_skip_nonzero,
        phase_reg == jssf_pkg::PH_SKIP, skip_left_reg != 16'd0,
        "skip phase with nothing left to skip")

    `JSSF_ASSERT_NEXT(a_verdict_parks,
        consume && hit && !last_reg, (phase_reg == jssf_pkg::PH_WAIT) && out_valid_reg,
        "verdict did not park the parser")

    `JSSF_ASSERT_NEXT(a_last_rearms,
        consume && last_reg, (phase_reg == jssf_pkg::PH_MHIGH) && (byte_count_reg == '0),
        "last byte did not re-arm the parser")

endmodule

`default_nettype wire
